// ===== hdl/tcce_pkg.sv =====
// shared types, constants and helpers for the text console cursor engine
package tcce_pkg;

    // configuration port
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 8;

    localparam logic [CfgIndexW-1:0] REG_COLUMNS    = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_ROWS       = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_TAB_STEP   = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_TAB_ORIGIN = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_WIDE_UNITS = 3'd4;

    // register reset values
    localparam logic [7:0] COLUMNS_RST    = 8'd80;
    localparam logic [7:0] ROWS_RST       = 8'd24;
    localparam logic [7:0] TAB_STEP_RST   = 8'd4;
    localparam logic [7:0] TAB_ORIGIN_RST = 8'd0;

    // result kinds
    localparam logic [1:0] KIND_GLYPH  = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // character codes
    localparam logic [15:0] CHR_TAB     = 16'h0009;
    localparam logic [15:0] CHR_NL      = 16'h000a;
    localparam logic [15:0] CHR_SPACE   = 16'h0020;
    localparam logic [15:0] ASCII_LIMIT = 16'h0080;
    localparam logic [15:0] NARROW_LO   = 16'hff60;
    localparam logic [15:0] NARROW_HI   = 16'hff9f;

    // utf-8 lead byte ranges
    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_LO = 8'he0;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] BYTE_ASCII_LIMIT = 8'h80;

    // tab remainder unit: one quotient bit per cycle over a 9-bit magnitude
    localparam int DivSteps = 9;
    localparam int DivCntW  = 4;
    localparam logic [DivCntW-1:0] DIV_LAST = DivCntW'(DivSteps - 1);

    // pending result flags, sent in this order
    localparam int NumFlags   = 4;
    localparam int FLAG_PRE   = 0;
    localparam int FLAG_GLYPH = 1;
    localparam int FLAG_POST  = 2;
    localparam int FLAG_END   = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_DIV,
        ST_TAB,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_END,
        ACT_CHAR
    } act_t;

    typedef struct packed {
        logic take;
        logic char_step;
        logic div_step;
        logic tab_fin;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        act_t act;
        logic is_tab;
        logic div_last;
        logic flags_none;
        logic flags_single;
        logic out_free;
    } dp_status_t;

    // zero register value acts as one
    function automatic logic [7:0] eff8(input logic [7:0] v);
        eff8 = (v == 8'd0) ? 8'd1 : v;
    endfunction

    // advance one row, clamp at the last row; msb flags a scroll
    function automatic logic [8:0] row_adv(input logic [7:0] cy, input logic [7:0] nr);
        logic [8:0] sum;
        sum = {1'b0, cy} + 9'd1;
        if (sum >= {1'b0, nr}) begin
            row_adv = {1'b1, nr - 8'd1};
        end else begin
            row_adv = {1'b0, sum[7:0]};
        end
    endfunction

endpackage

// ===== hdl/text_console_cursor_engine_unit.sv =====
// top level of the text console cursor engine
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+--------------------------------------------
//  s_      | in  | s_valid/s_ready   | code (utf-8 byte or utf-16 unit)
//  m_      | out | m_valid/m_ready   | kind, glyph_*, cursor_*, box_*, last
//  cfg_    | in  | cfg_we            | cfg_index, cfg_data (columns..wide_units)
//
// one input transaction at a time; a byte that only extends a utf-8 sequence
// gives no result, an end of string goes straight to sending its result, a
// glyph or newline passes the char state first (a glyph gives at least one
// result), a tab passes the char, remainder and tab states first: its
// remainder by tab_step comes from a restoring unit that resolves one bit per
// cycle over 9 steps. the last result sits in the output register while the
// next input is taken. reset (aresetn, synchronous, active low) restores
// register defaults and homes the cursor; results hold while m_ready is low.
module text_console_cursor_engine_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [15:0]                         s_code,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_kind,
    output logic [15:0]                         m_glyph_code,
    output logic [7:0]                          m_glyph_col,
    output logic [7:0]                          m_glyph_row,
    output logic                                m_glyph_wide,
    output logic [7:0]                          m_cursor_col,
    output logic [7:0]                          m_cursor_row,
    output logic [7:0]                          m_box_left,
    output logic [7:0]                          m_box_right,
    output logic [7:0]                          m_box_top,
    output logic [7:0]                          m_box_bottom,
    output logic                                m_last,
    input  logic                                cfg_we,
    input  logic [tcce_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [tcce_pkg::CfgDataW-1:0]       cfg_data
);

    tcce_pkg::dp_cmd_t    cmd;
    tcce_pkg::dp_status_t status;

    // controller
    tcce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    tcce_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_code       (s_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_glyph_code (m_glyph_code),
        .m_glyph_col  (m_glyph_col),
        .m_glyph_row  (m_glyph_row),
        .m_glyph_wide (m_glyph_wide),
        .m_cursor_col (m_cursor_col),
        .m_cursor_row (m_cursor_row),
        .m_box_left   (m_box_left),
        .m_box_right  (m_box_right),
        .m_box_top    (m_box_top),
        .m_box_bottom (m_box_bottom),
        .m_last       (m_last)
    );

endmodule

// ===== hdl/tcce_ctrl.sv =====
// controller state machine for the text console cursor engine
module tcce_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tcce_pkg::dp_status_t  status,
    output tcce_pkg::dp_cmd_t     cmd
);

    tcce_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcce_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcce_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (status.act)
                        tcce_pkg::ACT_END:  state_next = tcce_pkg::ST_EMIT;
                        tcce_pkg::ACT_CHAR: state_next = tcce_pkg::ST_CHAR;
                        default:            state_next = tcce_pkg::ST_IDLE;
                    endcase
                end
            end
            tcce_pkg::ST_CHAR: begin
                state_next = status.is_tab ? tcce_pkg::ST_DIV : tcce_pkg::ST_EMIT;
            end
            tcce_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = tcce_pkg::ST_TAB;
                end
            end
            tcce_pkg::ST_TAB: begin
                state_next = tcce_pkg::ST_EMIT;
            end
            tcce_pkg::ST_EMIT: begin
                if (status.flags_none) begin
                    state_next = tcce_pkg::ST_IDLE;
                end else if (status.out_free && status.flags_single) begin
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            default: state_next = tcce_pkg::ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        s_ready       = (state_reg == tcce_pkg::ST_IDLE);
        cmd.take      = (state_reg == tcce_pkg::ST_IDLE) && s_valid;
        cmd.char_step = (state_reg == tcce_pkg::ST_CHAR);
        cmd.div_step  = (state_reg == tcce_pkg::ST_DIV);
        cmd.tab_fin   = (state_reg == tcce_pkg::ST_TAB);
        cmd.load_out  = (state_reg == tcce_pkg::ST_EMIT) && !status.flags_none
                        && status.out_free;
    end

endmodule

// ===== hdl/tcce_datapath.sv =====
// datapath: utf decode, cursor and bounds, tab remainder unit, result register
module tcce_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tcce_pkg::dp_cmd_t                   cmd,
    output tcce_pkg::dp_status_t                status,
    input  logic                                cfg_we,
    input  logic [tcce_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [tcce_pkg::CfgDataW-1:0]       cfg_data,
    input  logic [15:0]                         s_code,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_kind,
    output logic [15:0]                         m_glyph_code,
    output logic [7:0]                          m_glyph_col,
    output logic [7:0]                          m_glyph_row,
    output logic                                m_glyph_wide,
    output logic [7:0]                          m_cursor_col,
    output logic [7:0]                          m_cursor_row,
    output logic [7:0]                          m_box_left,
    output logic [7:0]                          m_box_right,
    output logic [7:0]                          m_box_top,
    output logic [7:0]                          m_box_bottom,
    output logic                                m_last
);

    // configuration registers
    logic [7:0] columns_reg, rows_reg, tab_step_reg, tab_origin_reg;
    logic       wide_units_reg;

    // cursor, bounds and decoder state
    logic [7:0]  cur_col_reg, cur_row_reg;
    logic [7:0]  left_reg, right_reg, top_reg, bottom_reg;
    logic [1:0]  pending_reg;
    logic [15:0] partial_reg;

    // per-transaction working registers
    logic [15:0] uc_reg;
    logic [7:0]  glyph_col_reg, glyph_row_reg;
    logic        glyph_wide_reg;
    logic [tcce_pkg::NumFlags-1:0] flags_reg;

    // tab remainder unit
    logic [7:0]                  rem_reg;
    logic [8:0]                  dvd_reg;
    logic                        neg_reg;
    logic [tcce_pkg::DivCntW-1:0] div_cnt_reg;

    // result register
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [15:0] m_glyph_code_reg;
    logic [7:0]  m_glyph_col_reg, m_glyph_row_reg;
    logic        m_glyph_wide_reg;
    logic [7:0]  m_cursor_col_reg, m_cursor_row_reg;
    logic [7:0]  m_box_left_reg, m_box_right_reg, m_box_top_reg, m_box_bottom_reg;
    logic        m_last_reg;

    // effective register values
    logic [7:0] nc, nr, ts;
    assign nc = tcce_pkg::eff8(columns_reg);
    assign nr = tcce_pkg::eff8(rows_reg);
    assign ts = tcce_pkg::eff8(tab_step_reg);

    // utf-8 / utf-16 decode of the incoming code
    logic [7:0]  b;
    logic [15:0] cont_sum;
    tcce_pkg::act_t act;
    logic [15:0] dec_uc;
    logic [1:0]  pending_next;
    logic [15:0] partial_next;

    assign b        = s_code[7:0];
    assign cont_sum = partial_reg + {10'd0, b[5:0]};

    always_comb begin
        act          = tcce_pkg::ACT_NONE;
        dec_uc       = s_code;
        pending_next = pending_reg;
        partial_next = partial_reg;
        if (wide_units_reg) begin
            pending_next = 2'd0;
            act = (s_code == 16'd0) ? tcce_pkg::ACT_END : tcce_pkg::ACT_CHAR;
        end else if (pending_reg != 2'd0) begin
            if (b == 8'd0) begin
                pending_next = 2'd0;
                act          = tcce_pkg::ACT_END;
            end else if (pending_reg >= 2'd2) begin
                partial_next = partial_reg | {4'd0, b[5:0], 6'd0};
                pending_next = 2'd1;
            end else begin
                pending_next = 2'd0;
                dec_uc       = cont_sum;
                act = (cont_sum == 16'd0) ? tcce_pkg::ACT_END : tcce_pkg::ACT_CHAR;
            end
        end else if (b == 8'd0) begin
            act = tcce_pkg::ACT_END;
        end else if (b < tcce_pkg::BYTE_ASCII_LIMIT) begin
            act    = tcce_pkg::ACT_CHAR;
            dec_uc = {8'd0, b};
        end else if (b >= tcce_pkg::LEAD2_LO && b <= tcce_pkg::LEAD2_HI) begin
            partial_next = {5'd0, b[4:0], 6'd0};
            pending_next = 2'd1;
        end else if (b >= tcce_pkg::LEAD3_LO && b <= tcce_pkg::LEAD3_HI) begin
            partial_next = {b[3:0], 12'd0};
            pending_next = 2'd2;
        end else begin
            act    = tcce_pkg::ACT_CHAR;
            dec_uc = tcce_pkg::CHR_SPACE;
        end
    end

    // character classification and glyph placement
    logic       is_nl, is_tab, wide, pre_wrap, post_wrap;
    logic [8:0] pre_adv, post_adv;
    logic [7:0] row1, col1;
    logic [8:0] cx2;

    always_comb begin
        is_nl     = (uc_reg == tcce_pkg::CHR_NL);
        is_tab    = (uc_reg == tcce_pkg::CHR_TAB);
        wide      = !((uc_reg < tcce_pkg::ASCII_LIMIT) ||
                      (uc_reg >= tcce_pkg::NARROW_LO && uc_reg <= tcce_pkg::NARROW_HI));
        pre_wrap  = is_nl || (wide && (cur_col_reg >= nc - 8'd1));
        pre_adv   = tcce_pkg::row_adv(cur_row_reg, nr);
        row1      = pre_wrap ? pre_adv[7:0] : cur_row_reg;
        col1      = pre_wrap ? 8'd0 : cur_col_reg;
        cx2       = {1'b0, col1} + (wide ? 9'd2 : 9'd1);
        post_wrap = (cx2 >= {1'b0, nc});
        post_adv  = tcce_pkg::row_adv(row1, nr);
    end

    // tab: n = col + step - origin, signed; magnitude feeds the remainder unit
    logic [9:0] tab_n, tab_n_neg;
    logic [8:0] tab_mag;
    assign tab_n     = {2'd0, cur_col_reg} + {2'd0, ts} - {2'd0, tab_origin_reg};
    assign tab_n_neg = ~tab_n + 10'd1;
    assign tab_mag   = tab_n[9] ? tab_n_neg[8:0] : tab_n[8:0];

    // one restoring remainder step
    logic [8:0] div_sh, div_sub;
    logic       div_ge;
    assign div_sh  = {rem_reg, dvd_reg[8]};
    assign div_ge  = (div_sh >= {1'b0, ts});
    assign div_sub = div_sh - {1'b0, ts};

    // tab target column from the remainder
    logic [9:0] tab_base, tab_cx;
    logic       tab_wrap;
    assign tab_base = {2'd0, cur_col_reg} + {2'd0, ts};
    assign tab_cx   = neg_reg ? (tab_base + {2'd0, rem_reg}) : (tab_base - {2'd0, rem_reg});
    assign tab_wrap = (tab_cx >= {2'd0, nc});

    // next result to send: lowest pending flag
    logic [tcce_pkg::NumFlags-1:0] flag_sel, flags_less;
    assign flag_sel   = flags_reg & (~flags_reg + tcce_pkg::NumFlags'(1));
    assign flags_less = flags_reg & (flags_reg - tcce_pkg::NumFlags'(1));

    // pending result sets for a new transaction, a character and a tab
    logic [tcce_pkg::NumFlags-1:0] flags_take, flags_char, flags_tab;

    always_comb begin
        flags_take = '0;
        flags_take[tcce_pkg::FLAG_END]   = (act == tcce_pkg::ACT_END);
        flags_char = '0;
        flags_char[tcce_pkg::FLAG_PRE]   = pre_wrap & pre_adv[8];
        flags_char[tcce_pkg::FLAG_GLYPH] = !is_nl;
        flags_char[tcce_pkg::FLAG_POST]  = !is_nl & post_wrap & post_adv[8];
        flags_tab  = '0;
        flags_tab[tcce_pkg::FLAG_PRE]    = tab_wrap & pre_adv[8];
    end

    // status to the controller
    always_comb begin
        status.act          = act;
        status.is_tab       = is_tab;
        status.div_last     = (div_cnt_reg == tcce_pkg::DIV_LAST);
        status.flags_none   = (flags_reg == '0);
        status.flags_single = (flags_reg != '0) && (flags_less == '0);
        status.out_free     = !m_valid_reg || m_ready;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg    <= tcce_pkg::COLUMNS_RST;
            rows_reg       <= tcce_pkg::ROWS_RST;
            tab_step_reg   <= tcce_pkg::TAB_STEP_RST;
            tab_origin_reg <= tcce_pkg::TAB_ORIGIN_RST;
            wide_units_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tcce_pkg::REG_COLUMNS:    columns_reg    <= cfg_data;
                tcce_pkg::REG_ROWS:       rows_reg       <= cfg_data;
                tcce_pkg::REG_TAB_STEP:   tab_step_reg   <= cfg_data;
                tcce_pkg::REG_TAB_ORIGIN: tab_origin_reg <= cfg_data;
                tcce_pkg::REG_WIDE_UNITS: wide_units_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // cursor, bounds, decoder state, pending flags, remainder step count and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= 8'd0;
            cur_row_reg <= 8'd0;
            left_reg    <= 8'd0;
            right_reg   <= 8'd0;
            top_reg     <= 8'd0;
            bottom_reg  <= 8'd0;
            pending_reg <= 2'd0;
            partial_reg <= 16'd0;
            flags_reg   <= '0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // new transaction
            if (cmd.take) begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                flags_reg   <= flags_take;
            end

            // newline, glyph, or tab setup
            if (cmd.char_step) begin
                if (is_tab) begin
                    div_cnt_reg <= '0;
                end else if (is_nl) begin
                    cur_col_reg <= 8'd0;
                    cur_row_reg <= row1;
                    flags_reg   <= flags_char;
                end else begin
                    cur_col_reg <= post_wrap ? 8'd0 : cx2[7:0];
                    cur_row_reg <= post_wrap ? post_adv[7:0] : row1;
                    flags_reg   <= flags_char;
                    if (cx2 < {1'b0, left_reg}) begin
                        left_reg <= cx2[7:0];
                    end
                    if (cx2 > {1'b0, right_reg}) begin
                        right_reg <= cx2[8] ? 8'hff : cx2[7:0];
                    end
                    if (row1 < top_reg) begin
                        top_reg <= row1;
                    end
                    if (row1 > bottom_reg) begin
                        bottom_reg <= row1;
                    end
                end
            end

            // remainder unit step count
            if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + tcce_pkg::DivCntW'(1);
            end

            // tab result
            if (cmd.tab_fin) begin
                cur_col_reg <= tab_wrap ? 8'd0 : tab_cx[7:0];
                cur_row_reg <= tab_wrap ? pre_adv[7:0] : cur_row_reg;
                flags_reg   <= flags_tab;
            end

            // send one result; end of string restarts the box at the cursor
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
                flags_reg   <= flags_reg & ~flag_sel;
                if (flag_sel[tcce_pkg::FLAG_END]) begin
                    left_reg   <= cur_col_reg;
                    right_reg  <= cur_col_reg;
                    top_reg    <= cur_row_reg;
                    bottom_reg <= cur_row_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            uc_reg <= dec_uc;
        end
        if (cmd.char_step) begin
            glyph_col_reg  <= col1;
            glyph_row_reg  <= row1;
            glyph_wide_reg <= wide;
            rem_reg        <= 8'd0;
            dvd_reg        <= tab_mag;
            neg_reg        <= tab_n[9];
        end
        if (cmd.div_step) begin
            rem_reg <= div_ge ? div_sub[7:0] : div_sh[7:0];
            dvd_reg <= {dvd_reg[7:0], 1'b0};
        end
    end

    // result payload register
    logic sel_glyph, sel_end;
    assign sel_glyph = flag_sel[tcce_pkg::FLAG_GLYPH];
    assign sel_end   = flag_sel[tcce_pkg::FLAG_END];

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_cursor_col_reg <= cur_col_reg;
            m_cursor_row_reg <= cur_row_reg;
            m_last_reg       <= (flags_less == '0);
            m_kind_reg       <= sel_glyph ? tcce_pkg::KIND_GLYPH :
                                (sel_end ? tcce_pkg::KIND_END : tcce_pkg::KIND_SCROLL);
            m_glyph_code_reg <= sel_glyph ? uc_reg : 16'd0;
            m_glyph_col_reg  <= sel_glyph ? glyph_col_reg : 8'd0;
            m_glyph_row_reg  <= sel_glyph ? glyph_row_reg : 8'd0;
            m_glyph_wide_reg <= sel_glyph & glyph_wide_reg;
            m_box_left_reg   <= sel_end ? left_reg : 8'd0;
            m_box_right_reg  <= sel_end ? right_reg : 8'd0;
            m_box_top_reg    <= sel_end ? top_reg : 8'd0;
            m_box_bottom_reg <= sel_end ? bottom_reg : 8'd0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_glyph_code = m_glyph_code_reg;
    assign m_glyph_col  = m_glyph_col_reg;
    assign m_glyph_row  = m_glyph_row_reg;
    assign m_glyph_wide = m_glyph_wide_reg;
    assign m_cursor_col = m_cursor_col_reg;
    assign m_cursor_row = m_cursor_row_reg;
    assign m_box_left   = m_box_left_reg;
    assign m_box_right  = m_box_right_reg;
    assign m_box_top    = m_box_top_reg;
    assign m_box_bottom = m_box_bottom_reg;
    assign m_last       = m_last_reg;

endmodule
